>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the port-level checker of the job slot tracker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/jsct_pkg.sv
// ----------------------------------------------------------------------------
// jsct_pkg
// Constants, codes, types and helpers of the job slot completion tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jsct_pkg;

    // default table depth
    localparam int SLOTS_DEF = 16;

    // field widths
    localparam int ID_W   = 4;
    localparam int ID_LSB = 16;
    localparam int TICK_W = 32;
    localparam int DUE_W  = TICK_W + 1;
    localparam int DATA_W = 32;

    // request types
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // bus byte offsets
    localparam logic [7:0] OFS_SUBMIT = 8'd72;
    localparam logic [7:0] OFS_FLAG   = 8'd40;
    localparam logic [7:0] OFS_RESULT = 8'd16;

    // result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_BAD_WRITE  = 2'd1;
    localparam logic [1:0] STAT_TRY_AGAIN  = 2'd2;
    localparam logic [1:0] STAT_BAD_ACCESS = 2'd3;

    // result read beat codes
    localparam logic [1:0] BEAT_ID    = 2'd0;
    localparam logic [1:0] BEAT_FILL1 = 2'd1;
    localparam logic [1:0] BEAT_FILL2 = 2'd2;

    // tick counter goes back to zero once it reaches this value
    localparam logic [TICK_W-1:0] WRAP_POINT = 32'hFFFF_FFFE;

    // slot RAM write port
    typedef struct packed {
        logic             we;
        logic [ID_W-1:0]  id;
        logic [DUE_W-1:0] due;
    } t_slot_wr;

    // bit-reverse a problem id
    function automatic logic [ID_W-1:0] rev_id(input logic [ID_W-1:0] v);
        logic [ID_W-1:0] r;
        for (int b = 0; b < ID_W; b++) begin
            r[ID_W-1-b] = v[b];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/jsct_slot_mem.sv
// ----------------------------------------------------------------------------
// jsct_slot_mem
// Slot RAM: problem id and due time per slot, one write and one registered
// read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsct_slot_mem #(
    parameter  int SLOTS = jsct_pkg::SLOTS_DEF,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                           i_clk,
    input  jsct_pkg::t_slot_wr             i_wr,
    input  logic [IDX_W-1:0]               i_wr_addr,
    input  logic [IDX_W-1:0]               i_rd_addr,
    output logic [jsct_pkg::ID_W-1:0]      o_rd_id,
    output logic [jsct_pkg::DUE_W-1:0]     o_rd_due
);

    logic [jsct_pkg::ID_W-1:0]  r_id_mem  [SLOTS];
    logic [jsct_pkg::DUE_W-1:0] r_due_mem [SLOTS];
    logic [jsct_pkg::ID_W-1:0]  r_rd_id;
    logic [jsct_pkg::DUE_W-1:0] r_rd_due;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_id_mem[i_wr_addr]  <= i_wr.id;
            r_due_mem[i_wr_addr] <= i_wr.due;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_id  <= r_id_mem[i_rd_addr];
        r_rd_due <= r_due_mem[i_rd_addr];
    end

    assign o_rd_id  = r_rd_id;
    assign o_rd_due = r_rd_due;

endmodule

>>> hw/rtl/job_slot_completion_tracker_top.sv
// ----------------------------------------------------------------------------
// job_slot_completion_tracker_top
// Job table of a stand-in solver device, driven by ticks and bus accesses.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; its result appears on
// o_status / o_read_data for one cycle with o_strobe, which the receiver must
// take then. Bus reads and writes that touch no slot finish at the accepting
// edge, so such beats can follow each other every cycle. A tick walks the
// whole table one slot per cycle through the slot RAM and the one due-time
// comparator. A submit write scans the used flags one slot per cycle for
// the lowest free slot, and the first beat of a result read scans for the
// lowest done slot the same way and then reads that slot's id from the slot
// RAM in S_RID. The result is strobed on the cycle busy drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module job_slot_completion_tracker_top #(
    parameter  int SLOTS  = jsct_pkg::SLOTS_DEF,
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int DCNT_W = $clog2(SLOTS + 2)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_req_type,
    input  logic [7:0]                    i_address,
    input  logic [63:0]                   i_id_word,
    input  logic [1:0]                    i_solve_delay,
    input  logic [31:0]                   i_fill_word,
    output logic                          o_strobe,
    output logic [1:0]                    o_status,
    output logic [jsct_pkg::DATA_W-1:0]   o_read_data
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TICK  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_RSCAN = 3'd3;
    localparam logic [2:0] S_RID   = 3'd4;

    logic [2:0]                      r_state,  n_state;
    logic [IDX_W-1:0]                r_idx,    n_idx;
    logic                            r_ev_vld, n_ev_vld;
    logic [IDX_W-1:0]                r_ev_idx, n_ev_idx;
    logic [SLOTS-1:0]                r_used,   n_used;
    logic [SLOTS-1:0]                r_done,   n_done;
    logic [jsct_pkg::TICK_W-1:0]     r_tick,   n_tick;
    logic [DCNT_W-1:0]               r_dcnt,   n_dcnt;
    logic [1:0]                      r_beat,   n_beat;
    logic                            r_strobe, n_strobe;
    logic [1:0]                      r_status, n_status;
    logic [jsct_pkg::DATA_W-1:0]     r_data,   n_data;
    logic [jsct_pkg::ID_W-1:0]       r_new_id, n_new_id;
    logic [1:0]                      r_delay,  n_delay;

    jsct_pkg::t_slot_wr              s_wr;
    logic [jsct_pkg::ID_W-1:0]       w_rd_id;
    logic [jsct_pkg::DUE_W-1:0]      w_rd_due;
    logic                            w_match;

    // slot RAM, read at the scan pointer every cycle
    jsct_slot_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr      (s_wr),
        .i_wr_addr (r_idx),
        .i_rd_addr (r_idx),
        .o_rd_id   (w_rd_id),
        .o_rd_due  (w_rd_due)
    );

    // shared due-time comparator
    assign w_match = (w_rd_due == {1'b0, r_tick});

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_ev_vld = r_ev_vld;
        n_ev_idx = r_ev_idx;
        n_used   = r_used;
        n_done   = r_done;
        n_tick   = r_tick;
        n_dcnt   = r_dcnt;
        n_beat   = r_beat;
        n_strobe = 1'b0;
        n_status = r_status;
        n_data   = r_data;
        n_new_id = r_new_id;
        n_delay  = r_delay;
        s_wr.we  = 1'b0;
        s_wr.id  = r_new_id;
        s_wr.due = {1'b0, r_tick} + jsct_pkg::DUE_W'(r_delay);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_idx    = '0;
                    n_ev_vld = 1'b0;
                    n_new_id = i_id_word[jsct_pkg::ID_LSB +: jsct_pkg::ID_W];
                    n_delay  = i_solve_delay;
                    unique case (i_req_type)
                        jsct_pkg::REQ_TICK: begin
                            n_tick  = r_tick + 1'b1;
                            n_state = S_TICK;
                        end
                        jsct_pkg::REQ_WRITE: begin
                            if (i_address == jsct_pkg::OFS_SUBMIT) begin
                                n_state = S_WRITE;
                            end else begin
                                n_strobe = 1'b1;
                                n_status = jsct_pkg::STAT_BAD_WRITE;
                                n_data   = '0;
                            end
                        end
                        jsct_pkg::REQ_READ: begin
                            n_strobe = 1'b1;
                            n_status = jsct_pkg::STAT_OK;
                            n_data   = '0;
                            priority if (i_address == jsct_pkg::OFS_FLAG) begin
                                n_data = jsct_pkg::DATA_W'(r_dcnt != '0);
                            end else if (i_address == jsct_pkg::OFS_RESULT) begin
                                unique case (r_beat)
                                    jsct_pkg::BEAT_ID: begin
                                        if (r_dcnt == '0) begin
                                            n_status = jsct_pkg::STAT_BAD_ACCESS;
                                        end else begin
                                            n_strobe = 1'b0;
                                            n_state  = S_RSCAN;
                                        end
                                    end
                                    jsct_pkg::BEAT_FILL1: begin
                                        n_data = i_fill_word;
                                        n_beat = jsct_pkg::BEAT_FILL2;
                                    end
                                    default: begin
                                        // last beat retires the job from the count
                                        n_data = i_fill_word;
                                        n_beat = jsct_pkg::BEAT_ID;
                                        if (r_dcnt != '0) begin
                                            n_dcnt = r_dcnt - 1'b1;
                                        end
                                    end
                                endcase
                            end else begin
                                n_status = jsct_pkg::STAT_BAD_ACCESS;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_status = jsct_pkg::STAT_BAD_ACCESS;
                            n_data   = '0;
                        end
                    endcase
                end
            end

            // walk all slots: issue RAM read, compare its registered data in the next cycle
            S_TICK: begin
                n_ev_vld = 1'b1;
                n_ev_idx = r_idx;
                if (r_idx != LAST) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_ev_vld) begin
                    if (r_used[r_ev_idx] && !r_done[r_ev_idx] && w_match) begin
                        n_done[r_ev_idx] = 1'b1;
                        n_dcnt           = r_dcnt + 1'b1;
                    end
                    if (r_ev_idx == LAST) begin
                        if (r_tick == jsct_pkg::WRAP_POINT) begin
                            n_tick = '0;
                        end
                        n_strobe = 1'b1;
                        n_status = jsct_pkg::STAT_OK;
                        n_data   = '0;
                        n_state  = S_IDLE;
                    end
                end
            end

            // lowest free slot takes the job; a full table answers bad write
            S_WRITE: begin
                if (!r_used[r_idx]) begin
                    s_wr.we       = 1'b1;
                    n_used[r_idx] = 1'b1;
                    n_done[r_idx] = 1'b0;
                    n_strobe      = 1'b1;
                    n_status      = jsct_pkg::STAT_OK;
                    n_data        = '0;
                    n_state       = S_IDLE;
                end else if (r_idx == LAST) begin
                    n_strobe = 1'b1;
                    n_status = jsct_pkg::STAT_BAD_WRITE;
                    n_data   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // lowest done slot is freed; its id is read next cycle; none done answers try again
            S_RSCAN: begin
                if (r_used[r_idx] && r_done[r_idx]) begin
                    n_used[r_idx] = 1'b0;
                    n_done[r_idx] = 1'b0;
                    n_beat        = jsct_pkg::BEAT_FILL1;
                    n_state       = S_RID;
                end else if (r_idx == LAST) begin
                    n_strobe = 1'b1;
                    n_status = jsct_pkg::STAT_TRY_AGAIN;
                    n_data   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_RID: begin
                n_strobe = 1'b1;
                n_status = jsct_pkg::STAT_OK;
                n_data   = jsct_pkg::DATA_W'(jsct_pkg::rev_id(w_rd_id));
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ev_vld <= 1'b0;
            r_used   <= '0;
            r_done   <= '0;
            r_tick   <= '0;
            r_dcnt   <= '0;
            r_beat   <= jsct_pkg::BEAT_ID;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ev_vld <= n_ev_vld;
            r_used   <= n_used;
            r_done   <= n_done;
            r_tick   <= n_tick;
            r_dcnt   <= n_dcnt;
            r_beat   <= n_beat;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_ev_idx <= n_ev_idx;
        r_status <= n_status;
        r_data   <= n_data;
        r_new_id <= n_new_id;
        r_delay  <= n_delay;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_read_data = r_data;

endmodule

>>> hw/rtl/jsct_checker.sv
// ----------------------------------------------------------------------------
// jsct_checker
// Port-level checks of the job slot tracker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [1:0]  o_status,
    input logic [31:0] o_read_data
);

    logic w_accept;
    logic w_err;

    assign w_accept = start && !busy;
    assign w_err    = o_strobe && (o_status != jsct_pkg::STAT_OK);

    // an accepted beat either answers at once or keeps the block busy
    `ASSERT_NXT(a_accept_progress, i_clk, i_rst_n, w_accept, busy || o_strobe, "beat dropped")

    // no result while an item is still at work
    `ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "strobe while busy")

    // finishing an item always delivers its result
    `ASSERT_IMP(a_fall_strobe, i_clk, i_rst_n, $fell(busy), o_strobe, "no result at busy fall")

    // back-to-back strobes need a fresh accept
    `ASSERT_NXT(a_single_strobe, i_clk, i_rst_n, o_strobe && !w_accept, !o_strobe, "double strobe")

    // failed beats carry zero data
    `ASSERT_IMP(a_err_zero, i_clk, i_rst_n, w_err, o_read_data == '0, "error result with data")

endmodule

bind job_slot_completion_tracker_top jsct_checker u_jsct_checker (.*);

>>> tb/job_table_checker.sv
// ----------------------------------------------------------------------------
// job_table_checker
// Watches the request and result channels of the job slot tracker. It keeps
// its own copy of the job table, works out the reply to every accepted beat
// and compares each strobed result, field by field, with the oldest reply
// still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module job_table_checker
    import jsct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_address,
    input  logic [63:0]       i_id_word,
    input  logic [1:0]        i_solve_delay,
    input  logic [31:0]       i_fill_word,
    input  logic              i_strobe,
    input  logic [1:0]        i_status,
    input  logic [DATA_W-1:0] i_read_data,
    output int                o_mismatches,
    output int                o_outstanding
);

    localparam int SLOTS = SLOTS_DEF;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] data;
    } t_job_reply;

    // shadow job table
    logic              slot_taken  [SLOTS];
    logic              slot_ready  [SLOTS];
    logic [ID_W-1:0]   slot_pid    [SLOTS];
    logic [DUE_W-1:0]  slot_due_at [SLOTS];
    logic [TICK_W-1:0] tick_now;
    int unsigned       ready_jobs;
    logic [1:0]        harvest_beat;

    t_job_reply replies_owed[$];
    int         mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        mismatches++;
        $display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic clear_table();
        for (int i = 0; i < SLOTS; i++) begin
            slot_taken[i]  = 1'b0;
            slot_ready[i]  = 1'b0;
            slot_pid[i]    = '0;
            slot_due_at[i] = '0;
        end
        tick_now     = '0;
        ready_jobs   = 0;
        harvest_beat = BEAT_ID;
    endtask

    // apply one beat to the shadow table and return the reply it earns
    function automatic t_job_reply step_job_table(
        input logic [1:0]  req,
        input logic [7:0]  addr,
        input logic [63:0] word,
        input logic [1:0]  dly,
        input logic [31:0] fill
    );
        t_job_reply r;
        logic       found;
        r.status = STAT_OK;
        r.data   = '0;
        found    = 1'b0;
        case (req)
            REQ_TICK: begin
                tick_now = tick_now + 1'b1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_taken[i] && !slot_ready[i] &&
                        slot_due_at[i] == {1'b0, tick_now}) begin
                        slot_ready[i] = 1'b1;
                        ready_jobs++;
                    end
                end
                // wrap only after the due compare
                if (tick_now == WRAP_POINT)
                    tick_now = '0;
            end
            REQ_WRITE: begin
                r.status = STAT_BAD_WRITE;
                if (addr == OFS_SUBMIT) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!found && !slot_taken[i]) begin
                            found          = 1'b1;
                            slot_taken[i]  = 1'b1;
                            slot_ready[i]  = 1'b0;
                            slot_pid[i]    = word[ID_LSB +: ID_W];
                            slot_due_at[i] = {1'b0, tick_now} + DUE_W'(dly);
                            r.status       = STAT_OK;
                        end
                    end
                end
            end
            REQ_READ: begin
                if (addr == OFS_FLAG) begin
                    r.data = DATA_W'(ready_jobs != 0);
                end else if (addr == OFS_RESULT) begin
                    case (harvest_beat)
                        BEAT_ID: begin
                            if (ready_jobs == 0) begin
                                r.status = STAT_BAD_ACCESS;
                            end else begin
                                // lowest finished slot hands out its id, reversed
                                r.status = STAT_TRY_AGAIN;
                                for (int i = 0; i < SLOTS; i++) begin
                                    if (!found && slot_taken[i] && slot_ready[i]) begin
                                        found = 1'b1;
                                        for (int b = 0; b < ID_W; b++)
                                            r.data[ID_W-1-b] = slot_pid[i][b];
                                        slot_taken[i] = 1'b0;
                                        slot_ready[i] = 1'b0;
                                        harvest_beat  = BEAT_FILL1;
                                        r.status      = STAT_OK;
                                    end
                                end
                            end
                        end
                        BEAT_FILL1: begin
                            r.data       = fill;
                            harvest_beat = BEAT_FILL2;
                        end
                        default: begin
                            r.data       = fill;
                            harvest_beat = BEAT_ID;
                            if (ready_jobs > 0)
                                ready_jobs--;
                        end
                    endcase
                end else begin
                    r.status = STAT_BAD_ACCESS;
                end
            end
            default: r.status = STAT_BAD_ACCESS;
        endcase
        return r;
    endfunction

    // results are compared before the beat of the same edge is booked
    always @(posedge i_clk) begin : watch
        t_job_reply want;
        if (!i_rst_n) begin
            clear_table();
            replies_owed.delete();
        end else begin
            if (i_strobe) begin
                if (replies_owed.size() == 0) begin
                    report("result with nothing owed", i_read_data, '0);
                end else begin
                    want = replies_owed.pop_front();
                    if (i_status !== want.status)
                        report("status", 32'(i_status), 32'(want.status));
                    if (i_read_data !== want.data)
                        report("read_data", i_read_data, want.data);
                end
            end
            if (i_start && !i_busy)
                replies_owed.push_back(step_job_table(i_req_type, i_address,
                    i_id_word, i_solve_delay, i_fill_word));
        end
        o_outstanding <= replies_owed.size();
    end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the job slot completion tracker. A short directed run covers
// each request kind, the field extremes, bad offsets, the unused request
// code and a job that never falls due; random job sequences follow (submit,
// tick, harvest, table fill, broken harvests and noise) under several
// sender idling phases. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import jsct_pkg::*;

    localparam logic [1:0] REQ_RESERVED = 2'd3;
    localparam int         BEAT_TARGET  = 1800;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic [1:0]  req_type      = '0;
    logic [7:0]  address       = '0;
    logic [63:0] id_word       = '0;
    logic [1:0]  solve_delay   = '0;
    logic [31:0] fill_word     = '0;
    logic        busy;
    logic        strobe;
    logic [1:0]  status;
    logic [DATA_W-1:0] read_data;

    int mismatches;
    int outstanding;
    int beats_sent  = 0;
    int idle_pct    = 0;
    int stuck_jobs  = 0;

    job_slot_completion_tracker_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (req_type),
        .i_address     (address),
        .i_id_word     (id_word),
        .i_solve_delay (solve_delay),
        .i_fill_word   (fill_word),
        .o_strobe      (strobe),
        .o_status      (status),
        .o_read_data   (read_data)
    );

    job_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req_type    (req_type),
        .i_address     (address),
        .i_id_word     (id_word),
        .i_solve_delay (solve_delay),
        .i_fill_word   (fill_word),
        .i_strobe      (strobe),
        .i_status      (status),
        .i_read_data   (read_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // hard stop should the block hang
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // a zero delay parks a job for good, so only a few are allowed
    function automatic logic [1:0] pick_delay();
        if (stuck_jobs < 3 && $urandom_range(0, 149) == 0) begin
            stuck_jobs++;
            return 2'd0;
        end
        return 2'($urandom_range(1, 3));
    endfunction

    function automatic logic [7:0] pick_address();
        case ($urandom_range(0, 5))
            0:       return OFS_SUBMIT;
            1:       return OFS_FLAG;
            2:       return OFS_RESULT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // optional idle gap, then one beat held until busy is low at an edge
    task automatic push_beat(input logic [1:0] req, input logic [7:0] addr,
                             input logic [63:0] word, input logic [1:0] dly,
                             input logic [31:0] fill);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start       <= 1'b1;
        req_type    <= req;
        address     <= addr;
        id_word     <= word;
        solve_delay <= dly;
        fill_word   <= fill;
        do @(posedge i_clk); while (busy);
        beats_sent++;
    endtask

    task automatic submit_job();
        push_beat(REQ_WRITE, OFS_SUBMIT, rand_word(), pick_delay(), $urandom);
    endtask

    task automatic tick_once();
        push_beat(REQ_TICK, 8'($urandom), rand_word(), 2'($urandom), $urandom);
    endtask

    task automatic result_read();
        push_beat(REQ_READ, OFS_RESULT, rand_word(), 2'($urandom), $urandom);
    endtask

    // done flag poll followed by the three result beats
    task automatic harvest_job();
        push_beat(REQ_READ, OFS_FLAG, rand_word(), 2'($urandom), $urandom);
        repeat (3) result_read();
    endtask

    task automatic noise_beat();
        push_beat(2'($urandom_range(0, 3)), pick_address(), rand_word(),
                  pick_delay(), $urandom);
    endtask

    // hold off until every owed result has come back
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin : stimulus
        int n_jobs;
        bit paused;
        paused = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, offsets, extremes, never-due job
        push_beat(REQ_READ,     OFS_RESULT,       '0,          2'd0, '0);
        push_beat(REQ_READ,     OFS_FLAG,         '1,          2'd3, '1);
        push_beat(REQ_WRITE,    OFS_SUBMIT,       '1,          2'd1, '0);
        push_beat(REQ_WRITE,    OFS_SUBMIT,       '0,          2'd3, '1);
        push_beat(REQ_WRITE,    OFS_SUBMIT,       rand_word(), 2'd2, $urandom);
        push_beat(REQ_WRITE,    OFS_SUBMIT + 8'd1, '1,         2'd1, '0);
        push_beat(REQ_WRITE,    8'hFF,            rand_word(), 2'd2, '0);
        push_beat(REQ_READ,     8'h00,            '1,          2'd1, '1);
        push_beat(REQ_RESERVED, OFS_RESULT,       '1,          2'd3, '1);
        push_beat(REQ_TICK,     8'hFF,            '1,          2'd3, '1);
        push_beat(REQ_READ,     OFS_FLAG,         '0,          2'd0, '0);
        push_beat(REQ_TICK,     8'h00,            '0,          2'd0, '0);
        push_beat(REQ_TICK,     OFS_SUBMIT,       rand_word(), 2'd1, $urandom);
        push_beat(REQ_READ,     OFS_RESULT,       rand_word(), 2'd1, '0);
        push_beat(REQ_READ,     OFS_RESULT,       rand_word(), 2'd2, '1);
        push_beat(REQ_READ,     OFS_RESULT,       rand_word(), 2'd3, '0);
        push_beat(REQ_READ,     OFS_RESULT,       '0,          2'd0, $urandom);
        push_beat(REQ_READ,     OFS_RESULT,       '1,          2'd3, $urandom);
        push_beat(REQ_READ,     OFS_RESULT,       '0,          2'd0, '1);
        push_beat(REQ_WRITE,    OFS_SUBMIT,       rand_word(), 2'd0, '0);
        stuck_jobs++;
        push_beat(REQ_TICK,     8'h00,            '0,          2'd0, '0);
        push_beat(REQ_READ,     OFS_RESULT,       rand_word(), 2'd1, '1);
        push_beat(REQ_READ,     OFS_RESULT,       rand_word(), 2'd1, '0);
        push_beat(REQ_READ,     OFS_RESULT,       rand_word(), 2'd1, '1);
        beats_sent = 0;

        // random job sequences across idling phases
        while (beats_sent < BEAT_TARGET) begin
            case ((beats_sent / 300) % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 58;
                2:       idle_pct = 0;
                default: idle_pct = 27;
            endcase
            if (!paused && beats_sent >= BEAT_TARGET / 2) begin
                drain();
                paused = 1'b1;
            end
            case ($urandom_range(0, 99)) inside
                [0:44]: begin
                    // submit, let them fall due, collect
                    n_jobs = $urandom_range(1, 4);
                    repeat (n_jobs) submit_job();
                    repeat ($urandom_range(1, 4)) tick_once();
                    if ($urandom_range(0, 3) != 0)
                        repeat (n_jobs) harvest_job();
                    else
                        repeat ($urandom_range(1, n_jobs)) harvest_job();
                end
                [45:59]: repeat ($urandom_range(1, 6)) tick_once();
                [60:74]: begin
                    // harvest cut short by other traffic
                    result_read();
                    noise_beat();
                    repeat ($urandom_range(0, 2)) result_read();
                    tick_once();
                end
                [75:97]: repeat ($urandom_range(1, 4)) noise_beat();
                default: begin
                    // run the table into the full case, then empty it
                    repeat (SLOTS_DEF + 1) submit_job();
                    repeat (4) tick_once();
                    repeat (SLOTS_DEF) harvest_job();
                end
            endcase
        end

        drain();
        repeat (SLOTS_DEF + 4) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
